/* sv/fpfa_pkg.sv */
`default_nettype none
package fpfa_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 8;
   localparam int SIZE_BITS_DEFAULT  = 16;

   localparam int ACTION_BITS = 2;
   localparam int INDEX_BITS  = 3;
   localparam int VALUE_BITS  = 16;
   localparam int STATUS_BITS = 2;
   localparam int MODE_BITS   = 2;
   localparam int COUNT_BITS  = 4;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [ACTION_BITS-1:0] ACTION_LOAD  = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACTION_ALLOC = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACTION_FREE  = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_ALLOCATED = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_FIT    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_UPDATED   = 2'd2;

   localparam logic [MODE_BITS-1:0] FIT_FIRST = 2'd0;
   localparam logic [MODE_BITS-1:0] FIT_BEST  = 2'd1;
   localparam logic [MODE_BITS-1:0] FIT_WORST = 2'd2;

   localparam logic [COUNT_BITS-1:0] BLOCKS_IN_USE_RESET = 4'd8;

   // register word index, taken from paddr[2]
   localparam logic REG_FIT_MODE      = 1'b0;
   localparam logic REG_BLOCKS_IN_USE = 1'b1;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic [INDEX_BITS-1:0]  block_index;
      logic [VALUE_BITS-1:0]  size_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [INDEX_BITS-1:0]  chosen_index;
      logic [VALUE_BITS-1:0]  chosen_size;
   } rsp_type;

   typedef struct packed {
      logic [MODE_BITS-1:0]  fit_mode;
      logic [COUNT_BITS-1:0] blocks_in_use;
   } cfg_type;

   typedef enum logic [1:0] {
      KIND_ALLOC,
      KIND_LOAD,
      KIND_FREE,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic update;
      logic commit;
   } cmd_type;

   typedef struct packed {
      kind_type in_kind;
      logic     limit_zero;
      logic     scan_last;
      logic     out_free;
   } stat_type;

endpackage
`default_nettype wire

/* sv/fpfa_csr.sv */
`default_nettype none
module fpfa_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fpfa_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [fpfa_pkg::DATA_BITS-1:0]  csr_pwdata,
   output logic      [fpfa_pkg::DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready,
   output fpfa_pkg::cfg_type                    cfg
);
   import fpfa_pkg::*;

   logic [MODE_BITS-1:0]  fit_mode_ff;
   logic [COUNT_BITS-1:0] blocks_ff;
   logic                  wr_en;
   logic                  reg_sel;

   assign csr_pready = 1'b1;
   assign reg_sel    = csr_paddr[2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff <= FIT_FIRST;
         blocks_ff   <= BLOCKS_IN_USE_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            REG_FIT_MODE:      fit_mode_ff <= csr_pwdata[MODE_BITS-1:0];
            REG_BLOCKS_IN_USE: blocks_ff   <= csr_pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_FIT_MODE:      csr_prdata = DATA_BITS'(fit_mode_ff);
         REG_BLOCKS_IN_USE: csr_prdata = DATA_BITS'(blocks_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.fit_mode      = fit_mode_ff;
   assign cfg.blocks_in_use = blocks_ff;

endmodule
`default_nettype wire

/* sv/fpfa_datapath.sv */
`default_nettype none
module fpfa_datapath #(
   parameter int NUM_BLOCKS = fpfa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fpfa_pkg::req_type  req_data,
   input  wire fpfa_pkg::cfg_type  cfg,
   input  wire fpfa_pkg::cmd_type  cmd,
   output fpfa_pkg::stat_type      stat,
   input  wire logic               rsp_stall,
   output logic                    rsp_valid,
   output fpfa_pkg::rsp_type       rsp_data
);
   import fpfa_pkg::*;

   localparam int          IW   = $clog2(NUM_BLOCKS);
   localparam int          LW   = $clog2(NUM_BLOCKS + 1);
   localparam logic [31:0] NB32 = 32'(NUM_BLOCKS);

   // partition sizes: one write/read port, read data registered
   logic [SIZE_BITS-1:0]  size_mem [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] size_vld_ff;
   logic [NUM_BLOCKS-1:0] busy_ff;
   logic [SIZE_BITS-1:0]  rd_ff;
   logic                  rd_vld_ff;

   kind_type              kind_ff;
   logic [INDEX_BITS-1:0] bidx_ff;
   logic [SIZE_BITS-1:0]  sval_ff;

   logic [IW-1:0]         scan_ff;
   logic                  eval_ff;
   logic [IW-1:0]         eval_idx_ff;
   logic                  found_ff;
   logic [IW-1:0]         pick_ff;
   logic [SIZE_BITS-1:0]  best_left_ff;
   logic [SIZE_BITS-1:0]  best_size_ff;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_in;

   kind_type              in_kind;
   logic                  in_range;
   logic [LW-1:0]         limit;
   logic [IW-1:0]         upd_addr;
   logic [IW-1:0]         rd_addr;
   logic                  rd_en;
   logic                  mem_we;
   logic [SIZE_BITS-1:0]  rd_size;
   logic [SIZE_BITS-1:0]  left;
   logic                  fits;
   logic                  take;

   // decode the offered transaction
   assign in_range = 32'(req_data.block_index) < NB32;

   always_comb begin
      case (req_data.action)
         ACTION_ALLOC: in_kind = KIND_ALLOC;
         ACTION_LOAD:  in_kind = in_range ? KIND_LOAD : KIND_NONE;
         ACTION_FREE:  in_kind = in_range ? KIND_FREE : KIND_NONE;
         default:      in_kind = KIND_NONE;
      endcase
   end

   assign limit = (32'(cfg.blocks_in_use) > NB32) ? LW'(NUM_BLOCKS)
                                                   : LW'(cfg.blocks_in_use);

   assign stat.in_kind    = in_kind;
   assign stat.limit_zero = (limit == '0);
   assign stat.scan_last  = ((LW'(scan_ff) + LW'(1)) == limit);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         kind_ff <= in_kind;
         bidx_ff <= req_data.block_index;
         sval_ff <= SIZE_BITS'(req_data.size_value);
      end
   end

   // memory port
   assign upd_addr = IW'(bidx_ff);
   assign mem_we   = cmd.update && (kind_ff == KIND_LOAD);
   assign rd_en    = cmd.issue || (cmd.update && (kind_ff == KIND_FREE));
   assign rd_addr  = cmd.update ? upd_addr : scan_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         size_mem[upd_addr] <= sval_ff;
      end
      if (rd_en) begin
         rd_ff     <= size_mem[rd_addr];
         rd_vld_ff <= size_vld_ff[rd_addr];
      end
   end

   assign rd_size = rd_vld_ff ? rd_ff : '0;

   // fit test on the entry read last cycle
   assign left = rd_size - sval_ff;
   assign fits = (rd_size >= sval_ff) && !busy_ff[eval_idx_ff];

   always_comb begin
      case (cfg.fit_mode)
         FIT_BEST:  take = !found_ff || (left <= best_left_ff);
         FIT_WORST: take = !found_ff || (left >= best_left_ff);
         default:   take = !found_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_vld_ff <= '0;
         busy_ff     <= '0;
         scan_ff     <= '0;
         eval_ff     <= 1'b0;
         found_ff    <= 1'b0;
      end else begin
         if (mem_we) begin
            size_vld_ff[upd_addr] <= 1'b1;
         end
         if (cmd.update) begin
            busy_ff[upd_addr] <= 1'b0;
         end
         // a zero-size grant leaves the partition free
         if (cmd.commit && (kind_ff == KIND_ALLOC) && found_ff) begin
            busy_ff[pick_ff] <= (sval_ff != '0);
         end
         eval_ff <= cmd.issue;
         if (cmd.start) begin
            scan_ff  <= '0;
            found_ff <= 1'b0;
         end else begin
            if (cmd.issue) begin
               scan_ff <= scan_ff + IW'(1);
            end
            if (eval_ff && fits && take) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         eval_idx_ff <= scan_ff;
      end
      if (eval_ff && fits && take) begin
         pick_ff      <= eval_idx_ff;
         best_left_ff <= left;
         best_size_ff <= rd_size;
      end
   end

   // result assembly
   always_comb begin
      rsp_in.status       = STATUS_UPDATED;
      rsp_in.chosen_index = '0;
      rsp_in.chosen_size  = '0;
      case (kind_ff)
         KIND_ALLOC: begin
            if (found_ff) begin
               rsp_in.status       = STATUS_ALLOCATED;
               rsp_in.chosen_index = INDEX_BITS'(pick_ff);
               rsp_in.chosen_size  = VALUE_BITS'(best_size_ff);
            end else begin
               rsp_in.status = STATUS_NO_FIT;
            end
         end
         KIND_LOAD: begin
            rsp_in.chosen_index = bidx_ff;
            rsp_in.chosen_size  = VALUE_BITS'(sval_ff);
         end
         KIND_FREE: begin
            rsp_in.chosen_index = bidx_ff;
            rsp_in.chosen_size  = VALUE_BITS'(rd_size);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

/* sv/fpfa_control.sv */
`default_nettype none
module fpfa_control (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire fpfa_pkg::stat_type stat,
   output fpfa_pkg::cmd_type       cmd
);
   import fpfa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      stall_ff;
   logic      accept;

   assign accept    = req_valid && !stall_ff;
   assign req_stall = stall_ff;

   assign cmd.start  = accept;
   assign cmd.issue  = (state_ff == ST_SCAN);
   assign cmd.update = (state_ff == ST_UPDATE);
   assign cmd.commit = (state_ff == ST_FINISH) && stat.out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         stall_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  stall_ff <= 1'b1;
                  case (stat.in_kind)
                     KIND_ALLOC: state_ff <= stat.limit_zero ? ST_FINISH : ST_SCAN;
                     KIND_LOAD:  state_ff <= ST_UPDATE;
                     KIND_FREE:  state_ff <= ST_UPDATE;
                     default:    state_ff <= ST_FINISH;
                  endcase
               end
            end
            ST_SCAN: begin
               if (stat.scan_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN:  state_ff <= ST_FINISH;
            ST_UPDATE: state_ff <= ST_FINISH;
            ST_FINISH: begin
               // hold until the output register can take the result
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  stall_ff <= 1'b0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               stall_ff <= 1'b0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

/* sv/fixed_partition_fit_allocator_unit.sv */
`default_nettype none
// Fixed-partition allocator with first, best and worst fit. Each transaction
// is a load (set a partition's size and free it), a free, or an allocate
// request, and each produces exactly one result. One transaction is worked
// at a time. An allocate request scans L partitions, where L is
// blocks_in_use clamped to NUM_BLOCKS; the scan reads one partition size
// per cycle through the single port of the size memory. A finished result
// sits in an output register, so the next transaction is taken while it
// waits. Sizes read as zero until loaded; no clearing pass is needed after
// reset.
module fixed_partition_fit_allocator_unit #(
   parameter int NUM_BLOCKS = fpfa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = fpfa_pkg::SIZE_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire fpfa_pkg::req_type               req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output fpfa_pkg::rsp_type                    rsp_data,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [fpfa_pkg::ADDR_BITS-1:0]  csr_paddr,
   input  wire logic [fpfa_pkg::DATA_BITS-1:0]  csr_pwdata,
   output logic      [fpfa_pkg::DATA_BITS-1:0]  csr_prdata,
   output logic                                 csr_pready
);
   import fpfa_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   fpfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fpfa_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   fpfa_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

endmodule
`default_nettype wire
